// ===== rtl/kce_pkg.sv =====
// Package for the k-means clustering engine.
// Holds field widths, codes and defaults shared by all engine modules; no dependencies.
`default_nettype none
package kce_pkg;

    localparam int ATTRS          = 4;
    localparam int DIST_W         = 43;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam int DEF_MAX_POINTS   = 256;
    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_COORD_WIDTH  = 16;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_LOAD_POINT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_CENTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START       = 2'd2;

    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_POINTS    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLUSTERS  = 2'd3;

    localparam int SLOT_W   = 8;
    localparam int MAXIT_W  = 8;
    localparam int NPOINT_W = 9;
    localparam int NCLUST_W = 4;
    localparam int INDEX_W  = 3;
    localparam int MEMBER_W = 9;

    localparam logic [MAXIT_W-1:0]  RST_MAX_ITER = 8'd50;
    localparam logic [NPOINT_W-1:0] RST_POINTS   = 9'd150;
    localparam logic [NCLUST_W-1:0] RST_CLUSTERS = 4'd3;

endpackage
`default_nettype wire

// ===== rtl/kce_lane.sv =====
// One distance lane: squared Euclidean distance from the current point to one center.
// Two register stages (squares, then sum). Uses kce_pkg.
`default_nettype none
module kce_lane
    import kce_pkg::*;
#(
    parameter int CW = DEF_COORD_WIDTH,
    parameter int DW = 2 * CW + 3
) (
    input  wire logic                 aclk,
    input  wire logic signed [CW-1:0] point  [ATTRS],
    input  wire logic signed [CW-1:0] center [ATTRS],
    output logic         [DW-1:0]     sq_dist
);
    localparam int SQW = 2 * CW + 1;

    logic signed [CW:0]      diff [ATTRS];
    logic signed [2*CW+1:0]  prod [ATTRS];
    logic        [SQW-1:0]   sq_reg [ATTRS];
    logic        [DW-1:0]    dist_reg;
    logic        [DW-1:0]    dist_next;

    always_comb begin
        for (int j = 0; j < ATTRS; j++) begin
            diff[j] = (CW+1)'(point[j]) - (CW+1)'(center[j]);
            prod[j] = diff[j] * diff[j];
        end
        dist_next = '0;
        for (int j = 0; j < ATTRS; j++) begin
            dist_next = dist_next + DW'(sq_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < ATTRS; j++) begin
            sq_reg[j] <= prod[j][SQW-1:0];
        end
        dist_reg <= dist_next;
    end

    assign sq_dist = dist_reg;

endmodule
`default_nettype wire

// ===== rtl/kce_merge.sv =====
// Merging stage: registered minimum tree over the lane distances, ties to the lower index.
// Lanes at or above the active cluster count are masked out. Uses kce_pkg.
`default_nettype none
module kce_merge
    import kce_pkg::*;
#(
    parameter int LANES = DEF_MAX_CLUSTERS,
    parameter int DW    = 2 * DEF_COORD_WIDTH + 3,
    parameter int KW    = (LANES > 1) ? $clog2(LANES) : 1,
    parameter int KCW   = $clog2(LANES + 1)
) (
    input  wire logic           aclk,
    input  wire logic [DW-1:0]  lane_dist [LANES],
    input  wire logic [KCW-1:0] active,
    output logic      [KW-1:0]  best_idx,
    output logic      [DW-1:0]  best_dist
);
    localparam int LV = (LANES > 1) ? $clog2(LANES) : 0;
    localparam int P  = 1 << LV;
    localparam int N  = 2 * P - 1;

    logic          node_v [N];
    logic [DW-1:0] node_d [N];
    logic [KW-1:0] node_i [N];
    logic          take_left;
    logic [KW-1:0] best_idx_reg;
    logic [DW-1:0] best_dist_reg;

    always_comb begin
        take_left = 1'b0;
        for (int i = 0; i < P; i++) begin
            if (i < LANES) begin
                node_v[P-1+i] = (i < int'(active));
                node_d[P-1+i] = lane_dist[i];
            end else begin
                node_v[P-1+i] = 1'b0;
                node_d[P-1+i] = '0;
            end
            node_i[P-1+i] = KW'(i);
        end
        for (int n = P - 2; n >= 0; n--) begin
            take_left = node_v[2*n+1] &&
                        (!node_v[2*n+2] || (node_d[2*n+1] <= node_d[2*n+2]));
            node_v[n] = node_v[2*n+1] || node_v[2*n+2];
            node_d[n] = take_left ? node_d[2*n+1] : node_d[2*n+2];
            node_i[n] = take_left ? node_i[2*n+1] : node_i[2*n+2];
        end
    end

    always_ff @(posedge aclk) begin
        best_idx_reg  <= node_i[0];
        best_dist_reg <= node_d[0];
    end

    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

endmodule
`default_nettype wire

// ===== rtl/kce_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Used for the center update. Uses kce_pkg.
`default_nettype none
module kce_div
    import kce_pkg::*;
#(
    parameter int NW  = 24,
    parameter int DVW = 9
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [NW-1:0] dividend,
    input  wire logic        [DVW-1:0] divisor,
    output logic                      done,
    output logic signed [NW-1:0]      quotient
);
    localparam int CNW = $clog2(NW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]  num_reg, num_next;
    logic [DVW:0]   rem_reg, rem_next;
    logic [DVW-1:0] dvs_reg, dvs_next;
    logic           neg_reg, neg_next;
    logic [DVW:0]   rem_sh;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[DVW-1:0], num_reg[NW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[NW-1];
            num_next  = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                num_next = {num_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                num_next = {num_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNW'(NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule
`default_nettype wire

// ===== rtl/kmeans_clustering_engine_top.sv =====
// Lloyd k-means engine. Load transactions are accepted one per cycle, back to back, while idle.
// A start transaction runs iterations of assignment, paced by the single point-memory read port
// and the four-stage distance pipeline (read, squares, sum, minimum), then a center update that
// runs the serial divider once per coordinate of each non-empty cluster and skips empty clusters;
// it then emits one result per cluster, one per cycle while m_tready is high. No new input meanwhile.
// Synchronous active-low reset restores the register defaults and zeroes the centers.
`default_nettype none
module kmeans_clustering_engine_top
    import kce_pkg::*;
#(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
    localparam int CW   = COORD_WIDTH,
    localparam int SDW  = ((SLOT_W + ATTRS * CW + 7) / 8) * 8,
    localparam int MRAW = INDEX_W + ATTRS * CW + MEMBER_W + DIST_W + MAXIT_W,
    localparam int MDW  = ((MRAW + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // slot, coord_a, coord_b, coord_c, coord_d
    input  wire logic [SDW-1:0]       s_tdata,
    // kind
    input  wire logic [KIND_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // center_index, center_a, center_b, center_c, center_d, member_count,
    // total_squared_distance, iterations_done
    output logic [MDW-1:0]            m_tdata,
    output logic                      m_tlast,
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [DIST_W-1:0]    cfg_wdata
);
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int PW   = $clog2(MAX_POINTS + 1);
    localparam int KW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int KCW  = $clog2(MAX_CLUSTERS + 1);
    localparam int DW   = 2 * CW + 3;
    localparam int SW   = CW + AW + 1;
    localparam int TW   = ((DW > DIST_W) ? DW : DIST_W) + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ASSIGN = 3'd1;
    localparam logic [2:0] ST_SEL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [MAXIT_W-1:0]  max_iter_reg;
    logic [DIST_W-1:0]   thresh_reg;
    logic [NPOINT_W-1:0] points_reg;
    logic [NCLUST_W-1:0] clusters_reg;

    logic [ATTRS*CW-1:0] point_mem [MAX_POINTS];
    logic [ATTRS*CW-1:0] rd_data_reg;

    logic signed [CW-1:0] center_reg [MAX_CLUSTERS][ATTRS];
    logic signed [SW-1:0] sums_reg   [MAX_CLUSTERS][ATTRS];
    logic        [PW-1:0] counts_reg [MAX_CLUSTERS];
    logic [DIST_W-1:0]    total_reg;
    logic [DIST_W-1:0]    prev_reg;
    logic [MAXIT_W-1:0]   iter_reg;

    logic [PW-1:0]  issue_reg;
    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    logic [ATTRS*CW-1:0] pt_d2_reg, pt_d3_reg, pt_d4_reg;
    logic [KCW-1:0] k_reg;
    logic [1:0]     j_reg;
    logic [KW-1:0]  e_reg;

    logic [PW-1:0]  np;
    logic [KCW-1:0] nk;
    logic [MAXIT_W-1:0] maxit;
    logic           accept;
    logic           do_clear;
    logic           issuing;

    logic signed [CW-1:0] lane_pt [ATTRS];
    logic [DW-1:0]  lane_dist [MAX_CLUSTERS];
    logic [KW-1:0]  best_idx;
    logic [DW-1:0]  best_dist;
    logic [TW-1:0]  total_sum;

    logic           div_start, div_done;
    logic signed [SW-1:0] div_q;
    logic [KW-1:0]  k_idx;

    logic [MAXIT_W-1:0] iter_inc;
    logic           stop;

    assign np = (int'(points_reg) > MAX_POINTS) ? PW'(MAX_POINTS) : PW'(points_reg);
    assign nk = (clusters_reg == '0) ? KCW'(1) :
                (int'(clusters_reg) > MAX_CLUSTERS) ? KCW'(MAX_CLUSTERS) : KCW'(clusters_reg);
    assign maxit = (max_iter_reg == '0) ? MAXIT_W'(1) : max_iter_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign issuing  = (state_reg == ST_ASSIGN) && (issue_reg < np);
    assign k_idx    = k_reg[KW-1:0];
    assign iter_inc = iter_reg + 1'b1;
    assign stop     = (total_reg >= prev_reg) || ((prev_reg - total_reg) <= thresh_reg);
    assign total_sum = TW'(total_reg) + TW'(best_dist);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= RST_MAX_ITER;
            thresh_reg   <= '0;
            points_reg   <= RST_POINTS;
            clusters_reg <= RST_CLUSTERS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_ITER:  max_iter_reg <= cfg_wdata[MAXIT_W-1:0];
                REG_THRESHOLD: thresh_reg   <= cfg_wdata;
                REG_POINTS:    points_reg   <= cfg_wdata[NPOINT_W-1:0];
                REG_CLUSTERS:  clusters_reg <= cfg_wdata[NCLUST_W-1:0];
                default: ;
            endcase
        end
    end

    // Point memory: written by load transactions, read once per point during assignment.
    always_ff @(posedge aclk) begin
        if (accept && s_tuser == KIND_LOAD_POINT &&
            int'(s_tdata[SLOT_W-1:0]) < MAX_POINTS) begin
            point_mem[AW'(s_tdata[SLOT_W-1:0])] <= s_tdata[SLOT_W +: ATTRS*CW];
        end
        rd_data_reg <= point_mem[issue_reg[AW-1:0]];
    end

    always_comb begin
        for (int j = 0; j < ATTRS; j++) begin
            lane_pt[j] = $signed(rd_data_reg[j*CW +: CW]);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_CLUSTERS; g++) begin : g_lane
            kce_lane #(.CW(CW), .DW(DW)) u_lane (
                .aclk    (aclk),
                .point   (lane_pt),
                .center  (center_reg[g]),
                .sq_dist (lane_dist[g])
            );
        end
    endgenerate

    kce_merge #(.LANES(MAX_CLUSTERS), .DW(DW), .KW(KW), .KCW(KCW)) u_merge (
        .aclk      (aclk),
        .lane_dist (lane_dist),
        .active    (nk),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

    kce_div #(.NW(SW), .DVW(PW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sums_reg[k_idx][j_reg]),
        .divisor  (counts_reg[k_idx]),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        do_clear   = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == KIND_START) begin
                    state_next = ST_ASSIGN;
                    do_clear   = 1'b1;
                end
            end
            ST_ASSIGN: begin
                if (!issuing && !v1_reg && !v2_reg && !v3_reg && !v4_reg) begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                if (k_reg == nk) begin
                    state_next = ST_CHECK;
                end else if (counts_reg[k_idx] != '0) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_SEL;
                end
            end
            ST_CHECK: begin
                if (iter_inc < maxit && !stop) begin
                    state_next = ST_ASSIGN;
                    do_clear   = 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_tready && KCW'(e_reg) == nk - 1'b1) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            issue_reg <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            e_reg     <= '0;
            total_reg <= '0;
            prev_reg  <= DIST_MAX;
            iter_reg  <= '0;
            for (int k = 0; k < MAX_CLUSTERS; k++) begin
                counts_reg[k] <= '0;
                for (int j = 0; j < ATTRS; j++) begin
                    center_reg[k][j] <= '0;
                    sums_reg[k][j]   <= '0;
                end
            end
        end else begin
            state_reg <= state_next;
            v1_reg    <= issuing;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            if (issuing) begin
                issue_reg <= issue_reg + 1'b1;
            end

            if (accept && s_tuser == KIND_LOAD_CENTER &&
                int'(s_tdata[SLOT_W-1:0]) < MAX_CLUSTERS) begin
                for (int j = 0; j < ATTRS; j++) begin
                    center_reg[KW'(s_tdata[SLOT_W-1:0])][j] <=
                        $signed(s_tdata[SLOT_W + j*CW +: CW]);
                end
            end

            if (accept && s_tuser == KIND_START) begin
                prev_reg <= DIST_MAX;
                iter_reg <= '0;
            end

            if (do_clear) begin
                issue_reg <= '0;
                total_reg <= '0;
                k_reg     <= '0;
                j_reg     <= '0;
                for (int k = 0; k < MAX_CLUSTERS; k++) begin
                    counts_reg[k] <= '0;
                    for (int j = 0; j < ATTRS; j++) begin
                        sums_reg[k][j] <= '0;
                    end
                end
            end

            // Accumulate the point into its nearest cluster.
            if (v4_reg) begin
                counts_reg[best_idx] <= counts_reg[best_idx] + 1'b1;
                for (int j = 0; j < ATTRS; j++) begin
                    sums_reg[best_idx][j] <= sums_reg[best_idx][j] +
                        SW'($signed(pt_d4_reg[j*CW +: CW]));
                end
                total_reg <= (total_sum > TW'(DIST_MAX)) ? DIST_MAX : total_sum[DIST_W-1:0];
            end

            // Empty clusters are skipped and keep their center.
            if (state_reg == ST_SEL && k_reg != nk && counts_reg[k_idx] == '0) begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == ST_DIV && div_done) begin
                center_reg[k_idx][j_reg] <= div_q[CW-1:0];
                j_reg <= j_reg + 1'b1;
                if (j_reg == 2'(ATTRS - 1)) begin
                    k_reg <= k_reg + 1'b1;
                end
            end

            if (state_reg == ST_CHECK) begin
                iter_reg <= iter_inc;
                prev_reg <= total_reg;
                e_reg    <= '0;
            end

            if (state_reg == ST_EMIT && m_tready) begin
                e_reg <= e_reg + 1'b1;
            end
        end
        pt_d2_reg <= rd_data_reg;
        pt_d3_reg <= pt_d2_reg;
        pt_d4_reg <= pt_d3_reg;
    end

    // Result transaction, taken straight from the held state.
    always_comb begin
        m_tdata = '0;
        m_tdata[INDEX_W-1:0] = INDEX_W'(e_reg);
        for (int j = 0; j < ATTRS; j++) begin
            m_tdata[INDEX_W + j*CW +: CW] = center_reg[e_reg][j];
        end
        m_tdata[INDEX_W + ATTRS*CW +: MEMBER_W] = MEMBER_W'(counts_reg[e_reg]);
        m_tdata[INDEX_W + ATTRS*CW + MEMBER_W +: DIST_W] = total_reg;
        m_tdata[INDEX_W + ATTRS*CW + MEMBER_W + DIST_W +: MAXIT_W] = iter_reg;
    end

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = (KCW'(e_reg) == nk - 1'b1);

endmodule
`default_nettype wire
